### design/bilinear_texture_sampler_core_defines.svh
// ----------------------------------------------------------------------------
// Bilinear texture sampler assertion macros
// Concurrent assertion wrappers shared by the sampler modules. Defining
// ASSERT_OFF turns every check into nothing.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BTS_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sampler check failed");
`define BTS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sampler implication failed");
`define BTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sampler next-cycle check failed");
`else
`define BTS_ASSERT(label, cond)
`define BTS_ASSERT_IMPL(label, ante, cons)
`define BTS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/bts_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Field widths, register indexes and shared types of the sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int COORD_W    = 18;
    localparam int CLAMP_W    = 17;
    localparam logic [CLAMP_W-1:0] COORD_ONE = 17'h10000;
    localparam int IDX_W      = 8;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int TEXEL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0]  REG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET      = 9'd256;

    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic [TEXEL_W-1:0] p00;
        logic [TEXEL_W-1:0] p10;
        logic [TEXEL_W-1:0] p01;
        logic [TEXEL_W-1:0] p11;
    } t_quad;

endpackage

### design/bts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/bts_coord.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler coordinate stages
// Clamps u and v to the unit range, then scales them by the texture size in
// use minus one into fixed-point texel positions.
// ----------------------------------------------------------------------------
`include "bilinear_texture_sampler_core_defines.svh"

module bts_coord #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_action,
    input  logic [bts_pkg::IDX_W-1:0]             i_col,
    input  logic [bts_pkg::IDX_W-1:0]             i_row,
    input  logic [bts_pkg::TEXEL_W-1:0]           i_value,
    input  logic signed [bts_pkg::COORD_W-1:0]    i_u,
    input  logic signed [bts_pkg::COORD_W-1:0]    i_v,
    input  logic [bts_pkg::CFG_DATA_W-1:0]        i_tex_width,
    input  logic [bts_pkg::CFG_DATA_W-1:0]        i_tex_height,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_sample,
    output logic [bts_pkg::IDX_W-1:0]             o_col,
    output logic [bts_pkg::IDX_W-1:0]             o_row,
    output logic [bts_pkg::TEXEL_W-1:0]           o_value,
    output logic [bts_pkg::CLAMP_W+$clog2(MAX_DIM)+((FRAC_BITS > 16) ? FRAC_BITS-16 : 0)-1:0] o_px,
    output logic [bts_pkg::CLAMP_W+$clog2(MAX_DIM)+((FRAC_BITS > 16) ? FRAC_BITS-16 : 0)-1:0] o_py,
    output logic [$clog2(MAX_DIM)-1:0]            o_wm1,
    output logic [$clog2(MAX_DIM)-1:0]            o_hm1
);

    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int CMP_W      = (DIM_W + 1 > bts_pkg::CFG_DATA_W) ? DIM_W + 1
                                                                   : bts_pkg::CFG_DATA_W;
    localparam int UP_SHIFT   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int DOWN_SHIFT = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int PROD_W     = bts_pkg::CLAMP_W + DIM_W;
    localparam int POS_W      = PROD_W + UP_SHIFT;

    function automatic logic [bts_pkg::CLAMP_W-1:0] clamp_coord(
        input logic signed [bts_pkg::COORD_W-1:0] c
    );
        logic [bts_pkg::CLAMP_W-1:0] r;
        if (c[bts_pkg::COORD_W-1]) begin
            r = '0;
        end else if (c[bts_pkg::COORD_W-2:0] > bts_pkg::COORD_ONE) begin
            r = bts_pkg::COORD_ONE;
        end else begin
            r = c[bts_pkg::COORD_W-2:0];
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] dim_m1(input logic [bts_pkg::CFG_DATA_W-1:0] d);
        logic [CMP_W-1:0] e;
        logic [DIM_W-1:0] r;
        e = CMP_W'(d);
        if (e == '0) begin
            r = '0;
        end else if (e > CMP_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM - 1);
        end else begin
            r = DIM_W'(e - CMP_W'(1));
        end
        return r;
    endfunction

    logic                          r_s1_valid;
    logic                          r_s1_sample;
    logic [bts_pkg::IDX_W-1:0]     r_s1_col;
    logic [bts_pkg::IDX_W-1:0]     r_s1_row;
    logic [bts_pkg::TEXEL_W-1:0]   r_s1_value;
    logic [bts_pkg::CLAMP_W-1:0]   r_s1_cu;
    logic [bts_pkg::CLAMP_W-1:0]   r_s1_cv;
    logic [DIM_W-1:0]              r_s1_wm1;
    logic [DIM_W-1:0]              r_s1_hm1;

    logic                          r_s2_valid;
    logic                          r_s2_sample;
    logic [bts_pkg::IDX_W-1:0]     r_s2_col;
    logic [bts_pkg::IDX_W-1:0]     r_s2_row;
    logic [bts_pkg::TEXEL_W-1:0]   r_s2_value;
    logic [POS_W-1:0]              r_s2_px;
    logic [POS_W-1:0]              r_s2_py;
    logic [DIM_W-1:0]              r_s2_wm1;
    logic [DIM_W-1:0]              r_s2_hm1;

    logic              en1;
    logic              en2;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;

    assign en2     = !r_s2_valid || i_ready;
    assign en1     = !r_s1_valid || en2;
    assign o_ready = en1;

    always_comb begin
        prod_x = PROD_W'(r_s1_cu) * PROD_W'(r_s1_wm1);
        prod_y = PROD_W'(r_s1_cv) * PROD_W'(r_s1_hm1);
        pos_x  = (POS_W'(prod_x) << UP_SHIFT) >> DOWN_SHIFT;
        pos_y  = (POS_W'(prod_y) << UP_SHIFT) >> DOWN_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_valid <= i_valid;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_s1_sample <= (i_action == bts_pkg::ACT_SAMPLE);
            r_s1_col    <= i_col;
            r_s1_row    <= i_row;
            r_s1_value  <= i_value;
            r_s1_cu     <= clamp_coord(i_u);
            r_s1_cv     <= clamp_coord(i_v);
            r_s1_wm1    <= dim_m1(i_tex_width);
            r_s1_hm1    <= dim_m1(i_tex_height);
        end
        if (en2 && r_s1_valid) begin
            r_s2_sample <= r_s1_sample;
            r_s2_col    <= r_s1_col;
            r_s2_row    <= r_s1_row;
            r_s2_value  <= r_s1_value;
            r_s2_px     <= pos_x;
            r_s2_py     <= pos_y;
            r_s2_wm1    <= r_s1_wm1;
            r_s2_hm1    <= r_s1_hm1;
        end
    end

    assign o_valid  = r_s2_valid;
    assign o_sample = r_s2_sample;
    assign o_col    = r_s2_col;
    assign o_row    = r_s2_row;
    assign o_value  = r_s2_value;
    assign o_px     = r_s2_px;
    assign o_py     = r_s2_py;
    assign o_wm1    = r_s2_wm1;
    assign o_hm1    = r_s2_hm1;

    `BTS_ASSERT_NEXT(a_coord_hold, r_s2_valid && !i_ready, r_s2_valid && $stable(r_s2_px) && $stable(r_s2_sample))

endmodule

### design/bts_fetch.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler texel fetch
// Splits the texture into four banks by column and row parity so that the
// four neighbours of a sample are read in parallel. Write items store their
// texel at the same stage, which keeps writes and samples in order.
// ----------------------------------------------------------------------------
`include "bilinear_texture_sampler_core_defines.svh"

module bts_fetch #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_sample,
    input  logic [bts_pkg::IDX_W-1:0]             i_col,
    input  logic [bts_pkg::IDX_W-1:0]             i_row,
    input  logic [bts_pkg::TEXEL_W-1:0]           i_value,
    input  logic [bts_pkg::CLAMP_W+$clog2(MAX_DIM)+((FRAC_BITS > 16) ? FRAC_BITS-16 : 0)-1:0] i_px,
    input  logic [bts_pkg::CLAMP_W+$clog2(MAX_DIM)+((FRAC_BITS > 16) ? FRAC_BITS-16 : 0)-1:0] i_py,
    input  logic [$clog2(MAX_DIM)-1:0]            i_wm1,
    input  logic [$clog2(MAX_DIM)-1:0]            i_hm1,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output bts_pkg::t_quad                        o_quad,
    output logic [FRAC_BITS-1:0]                  o_fx,
    output logic [FRAC_BITS-1:0]                  o_fy
);

    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int CMP_W      = (DIM_W + 1 > bts_pkg::CFG_DATA_W) ? DIM_W + 1
                                                                   : bts_pkg::CFG_DATA_W;
    localparam int UP_SHIFT   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int POS_W      = bts_pkg::CLAMP_W + DIM_W + UP_SHIFT;
    localparam int INT_W      = POS_W - FRAC_BITS;
    localparam int HALF_W     = (DIM_W > 1) ? DIM_W - 1 : 1;
    localparam int ADDR_W     = 2 * HALF_W;
    localparam int BANK_DEPTH = 1 << ADDR_W;

    logic                   r_valid;
    logic [FRAC_BITS-1:0]   r_fx;
    logic [FRAC_BITS-1:0]   r_fy;
    logic                   r_x0_odd;
    logic                   r_x1_odd;
    logic                   r_y0_odd;
    logic                   r_y1_odd;

    logic [INT_W-1:0]             ix;
    logic [INT_W-1:0]             iy;
    logic [DIM_W-1:0]             x0;
    logic [DIM_W-1:0]             x1;
    logic [DIM_W-1:0]             y0;
    logic [DIM_W-1:0]             y1;
    logic [HALF_W-1:0]            col_half [2];
    logic [HALF_W-1:0]            row_half [2];
    logic [DIM_W-1:0]             wcol;
    logic [DIM_W-1:0]             wrow;
    logic                         wr_ok;
    logic                         take;
    logic [ADDR_W-1:0]            waddr;
    logic [3:0]                   bank_we;
    logic [bts_pkg::TEXEL_W-1:0]  rd [4];

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        ix = i_px[POS_W-1:FRAC_BITS];
        iy = i_py[POS_W-1:FRAC_BITS];
        x0 = (ix > INT_W'(i_wm1)) ? i_wm1 : ix[DIM_W-1:0];
        y0 = (iy > INT_W'(i_hm1)) ? i_hm1 : iy[DIM_W-1:0];
        x1 = (x0 < i_wm1) ? x0 + DIM_W'(1) : i_wm1;
        y1 = (y0 < i_hm1) ? y0 + DIM_W'(1) : i_hm1;
        for (int k = 0; k < 2; k++) begin
            col_half[k] = (x0[0] == 1'(k)) ? HALF_W'(x0 >> 1) : HALF_W'(x1 >> 1);
            row_half[k] = (y0[0] == 1'(k)) ? HALF_W'(y0 >> 1) : HALF_W'(y1 >> 1);
        end
        wcol  = DIM_W'(i_col);
        wrow  = DIM_W'(i_row);
        wr_ok = (CMP_W'(i_col) < CMP_W'(MAX_DIM)) && (CMP_W'(i_row) < CMP_W'(MAX_DIM));
        waddr = {HALF_W'(wrow >> 1), HALF_W'(wcol >> 1)};
        for (int b = 0; b < 4; b++) begin
            bank_we[b] = take && !i_sample && wr_ok && ({wrow[0], wcol[0]} == 2'(b));
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam int BX = b % 2;
        localparam int BY = b / 2;
        bts_ram #(
            .WIDTH (bts_pkg::TEXEL_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (waddr),
            .i_wdata (i_value),
            .i_re    (o_ready),
            .i_raddr ({row_half[BY], col_half[BX]}),
            .o_rdata (rd[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_fx     <= i_px[FRAC_BITS-1:0];
            r_fy     <= i_py[FRAC_BITS-1:0];
            r_x0_odd <= x0[0];
            r_x1_odd <= x1[0];
            r_y0_odd <= y0[0];
            r_y1_odd <= y1[0];
        end
    end

    always_comb begin
        o_quad.p00 = rd[{r_y0_odd, r_x0_odd}];
        o_quad.p10 = rd[{r_y0_odd, r_x1_odd}];
        o_quad.p01 = rd[{r_y1_odd, r_x0_odd}];
        o_quad.p11 = rd[{r_y1_odd, r_x1_odd}];
    end

    assign o_valid = r_valid;
    assign o_fx    = r_fx;
    assign o_fy    = r_fy;

    `BTS_ASSERT(a_fetch_one_bank, $onehot0(bank_we))
    `BTS_ASSERT_IMPL(a_fetch_nbr, i_valid && i_sample, (x1 >= x0) && (y1 >= y0) && (x1 <= i_wm1) && (y1 <= i_hm1))

endmodule

### design/bts_filter.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler filter
// Interpolates each channel horizontally in one stage and vertically in the
// next, then truncates and saturates the result to eight bits.
// ----------------------------------------------------------------------------
`include "bilinear_texture_sampler_core_defines.svh"

module bts_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  bts_pkg::t_quad            i_quad,
    input  logic [FRAC_BITS-1:0]      i_fx,
    input  logic [FRAC_BITS-1:0]      i_fy,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [bts_pkg::CH_W-1:0]  o_alpha,
    output logic [bts_pkg::CH_W-1:0]  o_red,
    output logic [bts_pkg::CH_W-1:0]  o_green,
    output logic [bts_pkg::CH_W-1:0]  o_blue
);

    localparam int CH_W = bts_pkg::CH_W;
    localparam int H_W  = CH_W + FRAC_BITS;
    localparam int HS_W = CH_W + FRAC_BITS + 2;
    localparam int RS_W = H_W + FRAC_BITS + 2;

    function automatic logic [H_W-1:0] lerp_h(
        input logic [CH_W-1:0]      a,
        input logic [CH_W-1:0]      b,
        input logic [FRAC_BITS-1:0] f
    );
        logic signed [CH_W:0]      d;
        logic signed [FRAC_BITS:0] fs;
        logic signed [HS_W-1:0]    prod;
        logic signed [HS_W-1:0]    sum;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        fs   = $signed({1'b0, f});
        prod = d * fs;
        sum  = $signed(HS_W'({a, {FRAC_BITS{1'b0}}})) + prod;
        return sum[H_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] lerp_v(
        input logic [H_W-1:0]       h0,
        input logic [H_W-1:0]       h1,
        input logic [FRAC_BITS-1:0] f
    );
        logic signed [H_W:0]       d;
        logic signed [FRAC_BITS:0] fs;
        logic signed [RS_W-1:0]    prod;
        logic signed [RS_W-1:0]    sum;
        logic [CH_W-1:0]           q;
        d    = $signed({1'b0, h1}) - $signed({1'b0, h0});
        fs   = $signed({1'b0, f});
        prod = d * fs;
        sum  = $signed(RS_W'({h0, {FRAC_BITS{1'b0}}})) + prod;
        if (sum[RS_W-1]) begin
            q = '0;
        end else if (|sum[RS_W-2:2*FRAC_BITS+CH_W]) begin
            q = '1;
        end else begin
            q = sum[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
        end
        return q;
    endfunction

    logic                  r_s4_valid;
    logic [H_W-1:0]        r_h0 [bts_pkg::NUM_CH];
    logic [H_W-1:0]        r_h1 [bts_pkg::NUM_CH];
    logic [FRAC_BITS-1:0]  r_fy;
    logic                  r_s5_valid;
    logic [CH_W-1:0]       r_out [bts_pkg::NUM_CH];

    logic                  en4;
    logic                  en5;
    logic [H_W-1:0]        n_h0 [bts_pkg::NUM_CH];
    logic [H_W-1:0]        n_h1 [bts_pkg::NUM_CH];
    logic [CH_W-1:0]       n_out [bts_pkg::NUM_CH];

    assign en5     = !r_s5_valid || i_ready;
    assign en4     = !r_s4_valid || en5;
    assign o_ready = en4;

    always_comb begin
        for (int k = 0; k < bts_pkg::NUM_CH; k++) begin
            n_h0[k] = lerp_h(i_quad.p00[bts_pkg::TEXEL_W-CH_W*(k+1) +: CH_W],
                             i_quad.p10[bts_pkg::TEXEL_W-CH_W*(k+1) +: CH_W], i_fx);
            n_h1[k] = lerp_h(i_quad.p01[bts_pkg::TEXEL_W-CH_W*(k+1) +: CH_W],
                             i_quad.p11[bts_pkg::TEXEL_W-CH_W*(k+1) +: CH_W], i_fx);
            n_out[k] = lerp_v(r_h0[k], r_h1[k], r_fy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (en4) begin
                r_s4_valid <= i_valid;
            end
            if (en5) begin
                r_s5_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && i_valid) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
            r_fy <= i_fy;
        end
        if (en5 && r_s4_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_s5_valid;
    assign o_alpha = r_out[0];
    assign o_red   = r_out[1];
    assign o_green = r_out[2];
    assign o_blue  = r_out[3];

    `BTS_ASSERT_NEXT(a_filter_hold, r_s4_valid && !en5, r_s4_valid && $stable(r_fy))

endmodule

### design/bilinear_texture_sampler_core.sv
// ----------------------------------------------------------------------------
// Bilinear texture sampler core
// A sample result passes coordinate stages s1 and s2, the fetch stage and
// filter stages s4 and s5 before it is valid. Throughput: one item per cycle
// unless the output stalls; the four texel banks serve all neighbours of a
// sample in one read. Write items produce no result. Reset clears the pipeline
// and sets both texture dimensions to 256; texel contents are not cleared.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_core #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic [bts_pkg::IDX_W-1:0]           i_texel_col,
    input  logic [bts_pkg::IDX_W-1:0]           i_texel_row,
    input  logic [bts_pkg::TEXEL_W-1:0]         i_texel_value,
    input  logic signed [bts_pkg::COORD_W-1:0]  i_u_coord,
    input  logic signed [bts_pkg::COORD_W-1:0]  i_v_coord,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [bts_pkg::CH_W-1:0]            o_out_alpha,
    output logic [bts_pkg::CH_W-1:0]            o_out_red,
    output logic [bts_pkg::CH_W-1:0]            o_out_green,
    output logic [bts_pkg::CH_W-1:0]            o_out_blue
);

    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int UP_SHIFT = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int POS_W    = bts_pkg::CLAMP_W + DIM_W + UP_SHIFT;

    logic [bts_pkg::CFG_DATA_W-1:0] r_tex_width;
    logic [bts_pkg::CFG_DATA_W-1:0] r_tex_height;

    logic                          c_valid;
    logic                          c_ready;
    logic                          c_sample;
    logic [bts_pkg::IDX_W-1:0]     c_col;
    logic [bts_pkg::IDX_W-1:0]     c_row;
    logic [bts_pkg::TEXEL_W-1:0]   c_value;
    logic [POS_W-1:0]              c_px;
    logic [POS_W-1:0]              c_py;
    logic [DIM_W-1:0]              c_wm1;
    logic [DIM_W-1:0]              c_hm1;

    logic                          f_valid;
    logic                          f_ready;
    bts_pkg::t_quad                f_quad;
    logic [FRAC_BITS-1:0]          f_fx;
    logic [FRAC_BITS-1:0]          f_fy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= bts_pkg::DIM_RESET;
            r_tex_height <= bts_pkg::DIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bts_pkg::REG_TEX_WIDTH: begin
                    r_tex_width <= i_cfg_data;
                end
                bts_pkg::REG_TEX_HEIGHT: begin
                    r_tex_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    bts_coord #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_coord (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_action     (i_action),
        .i_col        (i_texel_col),
        .i_row        (i_texel_row),
        .i_value      (i_texel_value),
        .i_u          (i_u_coord),
        .i_v          (i_v_coord),
        .i_tex_width  (r_tex_width),
        .i_tex_height (r_tex_height),
        .o_valid      (c_valid),
        .i_ready      (c_ready),
        .o_sample     (c_sample),
        .o_col        (c_col),
        .o_row        (c_row),
        .o_value      (c_value),
        .o_px         (c_px),
        .o_py         (c_py),
        .o_wm1        (c_wm1),
        .o_hm1        (c_hm1)
    );

    bts_fetch #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_fetch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid),
        .o_ready  (c_ready),
        .i_sample (c_sample),
        .i_col    (c_col),
        .i_row    (c_row),
        .i_value  (c_value),
        .i_px     (c_px),
        .i_py     (c_py),
        .i_wm1    (c_wm1),
        .i_hm1    (c_hm1),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_quad   (f_quad),
        .o_fx     (f_fx),
        .o_fy     (f_fy)
    );

    bts_filter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_quad  (f_quad),
        .i_fx    (f_fx),
        .i_fy    (f_fy),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_alpha (o_out_alpha),
        .o_red   (o_out_red),
        .o_green (o_out_green),
        .o_blue  (o_out_blue)
    );

endmodule
